/* design/fhpf_pkg.sv */
// Package for the farthest hit pair finder: field widths and the sequencer state type.
// No dependencies; imported by farthest_hit_pair_finder_core.
package fhpf_pkg;

  localparam int unsigned IN_W    = 24;  // coordinate, step length and energy ports
  localparam int unsigned COORD_W = 24;  // result coordinate ports
  localparam int unsigned DIST_W  = 50;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned CNT_W   = 20;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } fhpf_state_e;

endpackage

/* design/farthest_hit_pair_finder_core.sv */
// Farthest hit pair finder: hit store in one synchronous RAM, pairwise scan pipeline,
// result register. Depends on fhpf_pkg.
//
// Hits of one event enter one per cycle while loading and are written to the point RAM
// (MAX_HITS entries); step lengths, energies and the hit count are summed on the fly.
// The beat marked last_hit starts the pairwise scan over the n stored hits, which
// issues n*(n+1)/2 - 1 RAM reads, one read per cycle on the single read port: one
// fetch of point i, then one compared point j per read; the pipeline then fills and
// drains before the hand-off. With fewer than two stored hits no reads are issued.
// No input is taken during the scan. The result sits in an output register, so the
// next event's hits load while it waits. The RAM needs no clearing after reset.
module farthest_hit_pair_finder_core #(
  parameter int unsigned MAX_HITS   = 1024,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [fhpf_pkg::IN_W-1:0]    pos_x_i,
  input  logic signed [fhpf_pkg::IN_W-1:0]    pos_y_i,
  input  logic signed [fhpf_pkg::IN_W-1:0]    pos_z_i,
  input  logic        [fhpf_pkg::IN_W-1:0]    step_length_i,
  input  logic        [fhpf_pkg::IN_W-1:0]    energy_deposit_i,
  input  logic                                last_hit_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [fhpf_pkg::COORD_W-1:0] first_x_o,
  output logic signed [fhpf_pkg::COORD_W-1:0] first_y_o,
  output logic signed [fhpf_pkg::COORD_W-1:0] first_z_o,
  output logic signed [fhpf_pkg::COORD_W-1:0] second_x_o,
  output logic signed [fhpf_pkg::COORD_W-1:0] second_y_o,
  output logic signed [fhpf_pkg::COORD_W-1:0] second_z_o,
  output logic        [fhpf_pkg::DIST_W-1:0]  max_distance_sq_o,
  output logic        [fhpf_pkg::SUM_W-1:0]   total_length_o,
  output logic        [fhpf_pkg::SUM_W-1:0]   total_energy_o,
  output logic        [fhpf_pkg::CNT_W-1:0]   hit_count_o,
  output logic                                capacity_overflow_o
);
  import fhpf_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned AW = $clog2(MAX_HITS);
  localparam int unsigned CW = $clog2(MAX_HITS + 1);
  localparam int unsigned PW = 3 * CB;          // packed point {z, y, x}
  localparam int unsigned SW = 2 * CB + 1;      // one squared difference
  localparam int unsigned DW = 2 * CB + 3;      // sum of three squares

  function automatic logic [CB-1:0] coord_in(input logic [IN_W-1:0] raw);
    logic [CB+IN_W-1:0] e;
    e = {{CB{1'b0}}, raw};
    return e[CB-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] coord_out(input logic [CB-1:0] p);
    logic [CB+COORD_W-1:0] e;
    e = {{COORD_W{p[CB-1]}}, p};
    return e[COORD_W-1:0];
  endfunction

  // ---------------------------------------------------------------- control
  fhpf_state_e state_q, state_d;
  logic        in_fire, out_load, pipe_idle;

  logic [CW-1:0]    stored_q;
  logic [CNT_W-1:0] recv_q;
  logic [SUM_W-1:0] len_q, eng_q;
  logic             ovf_q;

  logic          issue_q, phase_ld_q;   // phase_ld_q: next read fetches point i
  logic [CW-1:0] i_q, j_q;
  logic          v1_q, tag_ld1_q, v2_q, v3_q, v4_q;

  assign in_fire   = in_valid_i && in_ready_o;
  assign pipe_idle = !issue_q && !v1_q && !v2_q && !v3_q && !v4_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: if (in_fire && last_hit_i) state_d = ST_SCAN;
      ST_SCAN: if (pipe_idle) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_LOAD: in_ready_o = 1'b1;
      ST_SCAN: ;
      ST_DONE: out_load = !out_valid_o || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- event sums
  logic              store_ok;
  logic [CW-1:0]     stored_d;
  logic [SUM_W:0]    len_sum, eng_sum;

  assign store_ok = stored_q < CW'(MAX_HITS);
  assign stored_d = store_ok ? stored_q + CW'(1) : stored_q;
  assign len_sum  = {1'b0, len_q} + (SUM_W+1)'(step_length_i);
  assign eng_sum  = {1'b0, eng_q} + (SUM_W+1)'(energy_deposit_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q <= '0;
      recv_q   <= '0;
      len_q    <= '0;
      eng_q    <= '0;
      ovf_q    <= 1'b0;
    end else if (out_load) begin
      stored_q <= '0;
      recv_q   <= '0;
      len_q    <= '0;
      eng_q    <= '0;
      ovf_q    <= 1'b0;
    end else if (in_fire) begin
      stored_q <= stored_d;
      if (!store_ok) ovf_q <= 1'b1;
      if (recv_q != '1) recv_q <= recv_q + CNT_W'(1);
      len_q <= len_sum[SUM_W] ? '1 : len_sum[SUM_W-1:0];
      eng_q <= eng_sum[SUM_W] ? '1 : eng_sum[SUM_W-1:0];
    end
  end

  // ---------------------------------------------------------------- point RAM
  logic [PW-1:0] mem [MAX_HITS];
  logic [PW-1:0] rd_q;
  logic [AW-1:0] rd_addr;

  assign rd_addr = phase_ld_q ? i_q[AW-1:0] : j_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_fire && store_ok) begin
      mem[stored_q[AW-1:0]] <= {coord_in(pos_z_i), coord_in(pos_y_i), coord_in(pos_x_i)};
    end
    if (issue_q) begin
      rd_q <= mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------- read sequencer
  // Order per i: fetch i, then j = i+1 .. n-1.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q    <= 1'b0;
      phase_ld_q <= 1'b1;
      i_q        <= '0;
      j_q        <= '0;
      v1_q       <= 1'b0;
      tag_ld1_q  <= 1'b0;
    end else begin
      v1_q      <= issue_q;
      tag_ld1_q <= phase_ld_q;
      if (in_fire && last_hit_i) begin
        issue_q    <= stored_d >= CW'(2);
        phase_ld_q <= 1'b1;
        i_q        <= '0;
        j_q        <= '0;
      end else if (issue_q) begin
        if (phase_ld_q) begin
          phase_ld_q <= 1'b0;
          j_q        <= i_q + CW'(1);
        end else if (j_q == stored_q - CW'(1)) begin
          if (i_q == stored_q - CW'(2)) begin
            issue_q <= 1'b0;
          end else begin
            phase_ld_q <= 1'b1;
            i_q        <= i_q + CW'(1);
          end
        end else begin
          j_q <= j_q + CW'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------- distance pipe
  logic [PW-1:0]        pi_q, pi2_q, pj2_q, pi3_q, pj3_q, pi4_q, pj4_q;
  logic [CB:0]          dx_q, dy_q, dz_q;
  logic [SW-1:0]        sqx_q, sqy_q, sqz_q;
  logic [DW-1:0]        dsum_q;
  logic signed [2*CB+1:0] px, py, pz;

  assign px = $signed(dx_q) * $signed(dx_q);
  assign py = $signed(dy_q) * $signed(dy_q);
  assign pz = $signed(dz_q) * $signed(dz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v2_q <= v1_q && !tag_ld1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && tag_ld1_q) pi_q <= rd_q;
    dx_q  <= {pi_q[CB-1], pi_q[CB-1:0]} - {rd_q[CB-1], rd_q[CB-1:0]};
    dy_q  <= {pi_q[2*CB-1], pi_q[2*CB-1:CB]} - {rd_q[2*CB-1], rd_q[2*CB-1:CB]};
    dz_q  <= {pi_q[3*CB-1], pi_q[3*CB-1:2*CB]} - {rd_q[3*CB-1], rd_q[3*CB-1:2*CB]};
    pi2_q <= pi_q;
    pj2_q <= rd_q;
    sqx_q <= px[SW-1:0];
    sqy_q <= py[SW-1:0];
    sqz_q <= pz[SW-1:0];
    pi3_q <= pi2_q;
    pj3_q <= pj2_q;
    dsum_q <= DW'(sqx_q) + DW'(sqy_q) + DW'(sqz_q);
    pi4_q  <= pi3_q;
    pj4_q  <= pj3_q;
  end

  // ---------------------------------------------------------------- best pair
  logic [DW-1:0] best_q;
  logic [PW-1:0] bp1_q, bp2_q;

  // strictly farther only, so the first farthest pair in scan order stays
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      bp1_q  <= '0;
      bp2_q  <= '0;
    end else if (out_load) begin
      best_q <= '0;
      bp1_q  <= '0;
      bp2_q  <= '0;
    end else if (v4_q && dsum_q > best_q) begin
      best_q <= dsum_q;
      bp1_q  <= pi4_q;
      bp2_q  <= pj4_q;
    end
  end

  // ---------------------------------------------------------------- result register
  logic [DW+DIST_W-1:0] best_ext;
  logic                 dist_sat;

  assign best_ext = {{DIST_W{1'b0}}, best_q};
  assign dist_sat = |(best_ext >> DIST_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      first_x_o           <= coord_out(bp1_q[CB-1:0]);
      first_y_o           <= coord_out(bp1_q[2*CB-1:CB]);
      first_z_o           <= coord_out(bp1_q[3*CB-1:2*CB]);
      second_x_o          <= coord_out(bp2_q[CB-1:0]);
      second_y_o          <= coord_out(bp2_q[2*CB-1:CB]);
      second_z_o          <= coord_out(bp2_q[3*CB-1:2*CB]);
      max_distance_sq_o   <= dist_sat ? '1 : best_ext[DIST_W-1:0];
      total_length_o      <= len_q;
      total_energy_o      <= eng_q;
      hit_count_o         <= recv_q;
      capacity_overflow_o <= ovf_q;
    end
  end

endmodule

/* tb/sv/farthest_hit_pair_finder_core_tb.sv */
`timescale 1ns / 100ps
// Testbench for farthest_hit_pair_finder_core: drives hit beats, predicts each event's result.
// Depends on fhpf_pkg and the core; self-checking, no files or arguments.
module farthest_hit_pair_finder_core_tb;
  import fhpf_pkg::*;

  localparam int unsigned STORE_DEPTH  = 1024;
  localparam int unsigned COORD_BITS   = 24;
  localparam int unsigned COUNT_MAX    = (1 << CNT_W) - 1;
  localparam int          STALL_LIMIT  = 50_000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          IDLE_PCT     = 22;
  localparam int          RANDOM_HITS  = 290;
  localparam int          LONG_HITS    = 100;

  localparam logic [IN_W-1:0] COORD_MIN  = 24'h80_0000;
  localparam logic [IN_W-1:0] COORD_MAX  = 24'h7F_FFFF;
  localparam logic [IN_W-1:0] AMOUNT_MAX = '1;

  typedef enum int {SPREAD_FULL, SPREAD_TIGHT, SPREAD_CORNERS} spread_e;

  typedef struct {
    logic [IN_W-1:0] x, y, z;
    logic [IN_W-1:0] step;
    logic [IN_W-1:0] nrg;
    bit              last;
    bit              calm;   // no idling on either side while set
  } hit_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] fx, fy, fz, sx, sy, sz;
    logic        [DIST_W-1:0]  dsq;
    logic        [SUM_W-1:0]   len;
    logic        [SUM_W-1:0]   nrg;
    logic        [CNT_W-1:0]   cnt;
    logic                      spill;
  } pair_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [IN_W-1:0]    pos_x_i = '0;
  logic signed [IN_W-1:0]    pos_y_i = '0;
  logic signed [IN_W-1:0]    pos_z_i = '0;
  logic        [IN_W-1:0]    step_length_i = '0;
  logic        [IN_W-1:0]    energy_deposit_i = '0;
  logic                      last_hit_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [COORD_W-1:0] first_x_o, first_y_o, first_z_o;
  logic signed [COORD_W-1:0] second_x_o, second_y_o, second_z_o;
  logic        [DIST_W-1:0]  max_distance_sq_o;
  logic        [SUM_W-1:0]   total_length_o;
  logic        [SUM_W-1:0]   total_energy_o;
  logic        [CNT_W-1:0]   hit_count_o;
  logic                      capacity_overflow_o;

  hit_t         hit_q[$];
  pair_result_t result_q[$];
  hit_t         cur_hit;
  bit           calm_r = 1'b0;
  int           n_errors = 0;
  int           n_results = 0;

  // event state of the predictor
  logic signed [COORD_W-1:0] pt_x[STORE_DEPTH];
  logic signed [COORD_W-1:0] pt_y[STORE_DEPTH];
  logic signed [COORD_W-1:0] pt_z[STORE_DEPTH];
  int unsigned               n_stored = 0;
  int unsigned               n_received = 0;
  logic [SUM_W-1:0]          len_sum = '0;
  logic [SUM_W-1:0]          nrg_sum = '0;
  bit                        spilled = 1'b0;

  farthest_hit_pair_finder_core #(
    .MAX_HITS  (STORE_DEPTH),
    .COORD_BITS(COORD_BITS)
  ) DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic flag_error(input string msg);
    if (n_errors < 100) $display("ERROR at %0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d %s: got %h expected %h", n_results, name, got, want));
  endtask

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, logic [IN_W-1:0] inc);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W+1)'(inc);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  // Folds one accepted hit into the event; on the last hit, scans all pairs i<j.
  task automatic absorb_hit(input hit_t h);
    pair_result_t r;
    longint       dx, dy, dz, d, best;
    int unsigned  bi, bj;
    bit           found;
    if (n_stored < STORE_DEPTH) begin
      pt_x[n_stored] = h.x;
      pt_y[n_stored] = h.y;
      pt_z[n_stored] = h.z;
      n_stored++;
    end else begin
      spilled = 1'b1;
    end
    len_sum = sat_sum(len_sum, h.step);
    nrg_sum = sat_sum(nrg_sum, h.nrg);
    if (n_received < COUNT_MAX) n_received++;
    if (!h.last) return;
    best  = 0;
    found = 1'b0;
    bi    = 0;
    bj    = 0;
    for (int unsigned i = 0; i < n_stored; i++) begin
      for (int unsigned j = i + 1; j < n_stored; j++) begin
        dx = longint'(pt_x[i]) - longint'(pt_x[j]);
        dy = longint'(pt_y[i]) - longint'(pt_y[j]);
        dz = longint'(pt_z[i]) - longint'(pt_z[j]);
        d  = dx * dx + dy * dy + dz * dz;
        if (d > best) begin  // strict: first farthest pair in scan order wins
          best  = d;
          bi    = i;
          bj    = j;
          found = 1'b1;
        end
      end
    end
    r = '0;
    if (found) begin
      r.fx = pt_x[bi]; r.fy = pt_y[bi]; r.fz = pt_z[bi];
      r.sx = pt_x[bj]; r.sy = pt_y[bj]; r.sz = pt_z[bj];
      r.dsq = best[DIST_W-1:0];
    end
    r.len   = len_sum;
    r.nrg   = nrg_sum;
    r.cnt   = CNT_W'(n_received);
    r.spill = spilled;
    result_q.push_back(r);
    n_stored   = 0;
    n_received = 0;
    len_sum    = '0;
    nrg_sum    = '0;
    spilled    = 1'b0;
  endtask

  function automatic void add_hit(input logic [IN_W-1:0] x, y, z, step, nrg, input bit last,
                                  input bit calm);
    hit_t h;
    h.x = x; h.y = y; h.z = z; h.step = step; h.nrg = nrg; h.last = last; h.calm = calm;
    hit_q.push_back(h);
  endfunction

  function automatic logic [IN_W-1:0] pick_coord(spread_e spread);
    case (spread)
      SPREAD_TIGHT: return IN_W'(int'($urandom_range(6)) - 3);  // small range: ties, repeats
      SPREAD_CORNERS: begin
        case ($urandom_range(3))
          0:       return COORD_MIN;
          1:       return COORD_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return IN_W'($urandom());
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pick_amount();
    case ($urandom_range(7))
      0:       return '0;
      1:       return AMOUNT_MAX;
      default: return IN_W'($urandom());
    endcase
  endfunction

  // Returns the number of hits queued.
  function automatic int queue_random_event(input bit calm);
    int      n, r;
    spread_e spread;
    r = $urandom_range(99);
    if (r < 10)      n = 1;
    else if (r < 20) n = $urandom_range(11, 40);
    else             n = $urandom_range(2, 10);
    spread = spread_e'($urandom_range(2));
    for (int k = 0; k < n; k++)
      add_hit(pick_coord(spread), pick_coord(spread), pick_coord(spread),
              pick_amount(), pick_amount(), k == n - 1, calm);
    return n;
  endfunction

  // driver: holds the beat until accepted, predicts on acceptance
  always @(posedge clk_i) begin : driver
    hit_t h;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      calm_r     <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) absorb_hit(cur_hit);
      if (!in_valid_i || in_ready_o) begin
        if (hit_q.size() != 0 && (calm_r || $urandom_range(99) >= IDLE_PCT)) begin
          h = hit_q.pop_front();
          cur_hit          <= h;
          in_valid_i       <= 1'b1;
          pos_x_i          <= h.x;
          pos_y_i          <= h.y;
          pos_z_i          <= h.z;
          step_length_i    <= h.step;
          energy_deposit_i <= h.nrg;
          last_hit_i       <= h.last;
          calm_r           <= h.calm;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat against the oldest prediction
  always @(posedge clk_i) begin : monitor
    pair_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm_r || ($urandom_range(99) >= IDLE_PCT);
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing expected", n_results));
        end else begin
          want = result_q.pop_front();
          compare_field("first_x", first_x_o, want.fx);
          compare_field("first_y", first_y_o, want.fy);
          compare_field("first_z", first_z_o, want.fz);
          compare_field("second_x", second_x_o, want.sx);
          compare_field("second_y", second_y_o, want.sy);
          compare_field("second_z", second_z_o, want.sz);
          compare_field("max_distance_sq", max_distance_sq_o, want.dsq);
          compare_field("total_length", total_length_o, want.len);
          compare_field("total_energy", total_energy_o, want.nrg);
          compare_field("hit_count", hit_count_o, want.cnt);
          compare_field("capacity_overflow", capacity_overflow_o, want.spill);
        end
        n_results++;
      end
    end
  end

  // watchdog: the longest event's scan runs with no beat on either side
  always @(posedge clk_i) begin : watchdog
    int quiet;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int n_random, n_events;
    // single hit: nothing to pair
    add_hit(COORD_MAX, COORD_MIN, 24'h5A_5A5A, AMOUNT_MAX, '0, 1'b1, 1'b0);
    // two coincident hits
    add_hit('1, '1, '1, 24'd7, 24'd9, 1'b0, 1'b0);
    add_hit('1, '1, '1, 24'd1, 24'd2, 1'b1, 1'b0);
    // opposite corners: largest possible distance
    add_hit(COORD_MIN, COORD_MIN, COORD_MIN, '0, AMOUNT_MAX, 1'b0, 1'b0);
    add_hit(COORD_MAX, COORD_MAX, COORD_MAX, AMOUNT_MAX, AMOUNT_MAX, 1'b1, 1'b0);
    // equal distances: pair (1,2) must beat the later tie (3,4)
    add_hit(24'd0, 24'd0, 24'd0, 24'd10, 24'd20, 1'b0, 1'b0);
    add_hit(24'd1, 24'd0, 24'd0, 24'd10, 24'd20, 1'b0, 1'b0);
    add_hit('1, 24'd0, 24'd0, 24'd10, 24'd20, 1'b0, 1'b0);
    add_hit(24'd0, 24'd1, 24'd0, 24'd10, 24'd20, 1'b0, 1'b0);
    add_hit(24'd0, '1, 24'd0, 24'd10, 24'd20, 1'b1, 1'b0);
    // all hits coincide
    for (int k = 0; k < 3; k++)
      add_hit(24'd123, -24'sd456, 24'd789, pick_amount(), pick_amount(), k == 2, 1'b0);
    // long event with full amounts; the last few hits sit at the corners
    for (int k = 0; k < LONG_HITS; k++) begin
      if (k < LONG_HITS - 8)
        add_hit(IN_W'(int'($urandom_range(2000)) - 1000),
                IN_W'(int'($urandom_range(2000)) - 1000),
                IN_W'(int'($urandom_range(2000)) - 1000), AMOUNT_MAX, AMOUNT_MAX, 1'b0, 1'b0);
      else
        add_hit(pick_coord(SPREAD_CORNERS), pick_coord(SPREAD_CORNERS),
                pick_coord(SPREAD_CORNERS), AMOUNT_MAX, AMOUNT_MAX,
                k == LONG_HITS - 1, 1'b0);
    end
    n_random = 0;
    n_events = 0;
    while (n_random < RANDOM_HITS) begin
      n_random += queue_random_event(n_events >= 12 && n_events < 22);
      n_events++;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (hit_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
